// ===== src/lfmc_pkg.sv =====
package lfmc_pkg;

  typedef struct packed {
    logic [1:0]  mode;
    logic [9:0]  gray_level;
    logic [9:0]  band_threshold;
    logic [7:0]  dead_zone;
    logic [7:0]  base_speed;
    logic [15:0] gain_p;
    logic [15:0] gain_i;
    logic [15:0] gain_d;
  } cfg_t;

  typedef enum logic [2:0] {
    REG_MODE,
    REG_GRAY_LEVEL,
    REG_BAND_THRESHOLD,
    REG_DEAD_ZONE,
    REG_BASE_SPEED,
    REG_GAIN_P,
    REG_GAIN_I,
    REG_GAIN_D
  } reg_idx_e;

  localparam logic [1:0] MODE_ONOFF = 2'd0;
  localparam logic [1:0] MODE_PROP  = 2'd1;
  localparam logic [1:0] MODE_PID   = 2'd2;

  localparam logic [1:0] DIR_HOLD = 2'd0;
  localparam logic [1:0] DIR_FWD  = 2'd1;
  localparam logic [1:0] DIR_REV  = 2'd2;

  localparam cfg_t CFG_RESET = '{
    mode:           MODE_PID,
    gray_level:     10'd512,
    band_threshold: 10'd100,
    dead_zone:      8'd0,
    base_speed:     8'd150,
    gain_p:         16'd256,
    gain_i:         16'd0,
    gain_d:         16'd0
  };

  localparam logic [7:0]  ON_BOOST        = 8'd50;
  localparam logic [15:0] PROP_GAIN_Q8    = 16'd256;
  localparam logic [7:0]  PROP_BASE_SPEED = 8'd150;

  localparam logic signed [27:0] INTEG_MAX  = 28'sd20000;
  localparam logic signed [27:0] INTEG_MIN  = -28'sd20000;
  localparam logic signed [15:0] INTEG_HIGH = 16'sd20000;
  localparam logic signed [15:0] INTEG_LOW  = -16'sd20000;

  localparam logic signed [39:0] SPEED_MAX = 40'sd255;
  localparam logic signed [39:0] SPEED_MIN = -40'sd255;

  // Quotient bits of the derivative division.
  localparam logic [4:0] DIV_STEPS = 5'd21;

  // Largest value of the scaled sum over 2048 that still divides by 125 to at most 50.
  localparam logic [12:0] ADJ_M_MAX = 13'd6374;
  // Ceiling of 2^20 / 125.
  localparam logic [13:0] RECIP_125 = 14'd8389;

  typedef enum logic [4:0] {
    OP_NONE,
    OP_LOAD,
    OP_ONOFF,
    OP_MUL_PROP,
    OP_SPEED_PROP,
    OP_MUL_ACC,
    OP_DIV_INIT,
    OP_DIV_STEP,
    OP_MUL_P,
    OP_MUL_D,
    OP_MUL_I,
    OP_SCALE,
    OP_SUM,
    OP_ADJ_SAT,
    OP_ADJ_MUL,
    OP_SPEED_PID,
    OP_WHEEL_MUL,
    OP_WHEEL_OUT
  } dp_op_e;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_DISPATCH,
    ST_ONOFF,
    ST_PMUL,
    ST_PSPEED,
    ST_IMUL,
    ST_DINIT,
    ST_DIV,
    ST_MULP,
    ST_MULD,
    ST_MULI,
    ST_SCALE,
    ST_SUM,
    ST_ADJ1,
    ST_ADJ2,
    ST_SPEED,
    ST_WMUL,
    ST_WOUT
  } ctrl_state_e;

  typedef struct packed {
    dp_op_e op;
  } cmd_t;

  typedef struct packed {
    logic ms_zero;
    logic div_done;
  } stat_t;

endpackage

// ===== src/lfmc_in_if.sv =====
interface lfmc_in_if;
  logic        valid;
  logic        ready;
  logic [9:0]  light_sample;
  logic [15:0] elapsed_ms;

  modport source (output valid, output light_sample, output elapsed_ms, input ready);
  modport sink (input valid, input light_sample, input elapsed_ms, output ready);
endinterface

// ===== src/lfmc_out_if.sv =====
interface lfmc_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] left_duty;
  logic [7:0] right_duty;
  logic [1:0] left_dir;
  logic [1:0] right_dir;

  modport source (output valid, output left_duty, output right_duty, output left_dir,
                  output right_dir, input ready);
  modport sink (input valid, input left_duty, input right_duty, input left_dir,
                input right_dir, output ready);
endinterface

// ===== src/lfmc_regs.sv =====
module lfmc_regs (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                we_i,
  input  logic [2:0]          idx_i,
  input  logic [15:0]         wdata_i,
  output lfmc_pkg::cfg_t      cfg_o
);

  lfmc_pkg::cfg_t cfg_q;
  lfmc_pkg::cfg_t cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (we_i) begin
      unique case (lfmc_pkg::reg_idx_e'(idx_i))
        lfmc_pkg::REG_MODE:           cfg_d.mode           = wdata_i[1:0];
        lfmc_pkg::REG_GRAY_LEVEL:     cfg_d.gray_level     = wdata_i[9:0];
        lfmc_pkg::REG_BAND_THRESHOLD: cfg_d.band_threshold = wdata_i[9:0];
        lfmc_pkg::REG_DEAD_ZONE:      cfg_d.dead_zone      = wdata_i[7:0];
        lfmc_pkg::REG_BASE_SPEED:     cfg_d.base_speed     = wdata_i[7:0];
        lfmc_pkg::REG_GAIN_P:         cfg_d.gain_p         = wdata_i;
        lfmc_pkg::REG_GAIN_I:         cfg_d.gain_i         = wdata_i;
        lfmc_pkg::REG_GAIN_D:         cfg_d.gain_d         = wdata_i;
        default:                      cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= lfmc_pkg::CFG_RESET;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

// ===== src/lfmc_dp.sv =====
module lfmc_dp (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  lfmc_pkg::cfg_t       cfg_i,
  input  lfmc_pkg::cmd_t       cmd_i,
  input  logic [9:0]           light_sample_i,
  input  logic [15:0]          elapsed_ms_i,
  output lfmc_pkg::stat_t      stat_o,
  output logic [7:0]           left_duty_o,
  output logic [7:0]           right_duty_o,
  output logic [1:0]           left_dir_o,
  output logic [1:0]           right_dir_o
);

  function automatic logic signed [8:0] clamp_speed(input logic signed [39:0] v);
    logic signed [8:0] r;
    if (v > lfmc_pkg::SPEED_MAX) begin
      r = 9'sd255;
    end else if (v < lfmc_pkg::SPEED_MIN) begin
      r = -9'sd255;
    end else begin
      r = v[8:0];
    end
    return r;
  endfunction

  // Division by 256 rounding toward zero.
  function automatic logic signed [39:0] div256_trunc(input logic signed [39:0] v);
    logic signed [39:0] q;
    q = v >>> 8;
    if (v[39] && (v[7:0] != 8'd0)) begin
      q = q + 40'sd1;
    end
    return q;
  endfunction

  // Exact floor of x / 255 for x up to 65279, plus the dead zone.
  function automatic logic [7:0] duty_of(input logic [15:0] x, input logic [7:0] dz,
                                         input logic zero);
    logic [16:0] s;
    logic [7:0]  d;
    s = {1'b0, x} + {9'd0, x[15:8]} + 17'd1;
    d = s[15:8] + dz;
    return zero ? 8'd0 : d;
  endfunction

  localparam logic [26:0] RECIP_125_W = {13'd0, lfmc_pkg::RECIP_125};

  logic [9:0]         sample_q;
  logic [15:0]        ms_q;
  logic signed [10:0] err_q;
  logic signed [38:0] prod_q;
  logic signed [15:0] acc_q;
  logic signed [15:0] integ_q;
  logic signed [10:0] last_err_q;
  logic [15:0]        rem_q;
  logic [20:0]        dvd_q;
  logic               neg_q;
  logic [4:0]         cnt_q;
  logic signed [48:0] t_q;
  logic [12:0]        m_q;
  logic               adj_neg_q;
  logic signed [6:0]  adj_q;
  logic signed [8:0]  spd_l_q;
  logic signed [8:0]  spd_r_q;
  logic [15:0]        wprod_l_q;
  logic [15:0]        wprod_r_q;
  logic               wzero_l_q;
  logic               wzero_r_q;
  logic [1:0]         wdir_l_q;
  logic [1:0]         wdir_r_q;
  logic [7:0]         left_duty_q;
  logic [7:0]         right_duty_q;
  logic [1:0]         left_dir_q;
  logic [1:0]         right_dir_q;

  logic [15:0]        mul_a;
  logic signed [22:0] mul_b;
  logic signed [39:0] mul_full;
  logic signed [22:0] der;
  logic [21:0]        der_pos;

  logic signed [10:0] err_new;
  logic signed [27:0] isum;
  logic signed [11:0] diff;
  logic signed [21:0] diff_x;
  logic signed [21:0] num;
  logic signed [21:0] num_neg;
  logic [16:0]        shifted;
  logic [17:0]        trial;

  logic signed [48:0] t_neg;
  logic [48:0]        t_mag;
  logic [37:0]        m_full;
  logic [26:0]        q_prod;
  logic [5:0]         q_adj;

  logic signed [39:0] prop_bias;
  logic signed [39:0] pe;
  logic signed [9:0]  pid_l;
  logic signed [9:0]  pid_r;

  logic signed [8:0]  spd_l_neg;
  logic signed [8:0]  spd_r_neg;
  logic [7:0]         mag_l;
  logic [7:0]         mag_r;
  logic [7:0]         span;

  logic signed [10:0] band_lo;
  logic [10:0]        band_hi;
  logic signed [10:0] samp_s;
  logic [8:0]         on_sum;
  logic [7:0]         on_duty;

  always_comb begin
    mul_a = 16'd0;
    mul_b = 23'sd0;
    case (cmd_i.op)
      lfmc_pkg::OP_MUL_ACC: begin
        mul_a = ms_q;
        mul_b = {{12{err_q[10]}}, err_q};
      end
      lfmc_pkg::OP_MUL_PROP: begin
        mul_a = lfmc_pkg::PROP_GAIN_Q8;
        mul_b = {{12{err_q[10]}}, err_q};
      end
      lfmc_pkg::OP_MUL_P: begin
        mul_a = cfg_i.gain_p;
        mul_b = {{12{err_q[10]}}, err_q};
      end
      lfmc_pkg::OP_MUL_D: begin
        mul_a = cfg_i.gain_d;
        mul_b = der;
      end
      lfmc_pkg::OP_MUL_I: begin
        mul_a = cfg_i.gain_i;
        mul_b = {{7{acc_q[15]}}, acc_q};
      end
      default: begin
        mul_a = 16'd0;
        mul_b = 23'sd0;
      end
    endcase
  end

  assign mul_full = $signed({24'd0, mul_a}) * $signed({{17{mul_b[22]}}, mul_b});

  assign der_pos = {1'b0, dvd_q};
  assign der     = neg_q ? -$signed({1'b0, der_pos}) : $signed({1'b0, der_pos});

  assign err_new = $signed({1'b0, light_sample_i}) - $signed({1'b0, cfg_i.gray_level});
  assign isum    = $signed({{12{integ_q[15]}}, integ_q}) + $signed(prod_q[27:0]);
  assign diff    = $signed({err_q[10], err_q}) - $signed({last_err_q[10], last_err_q});
  assign diff_x  = {{10{diff[11]}}, diff};
  assign num     = (diff_x <<< 10) - (diff_x <<< 4) - (diff_x <<< 3);
  assign num_neg = -num;
  assign shifted = {rem_q, dvd_q[20]};
  assign trial   = {1'b0, shifted} - {2'b0, ms_q};

  assign t_neg  = -t_q;
  assign t_mag  = t_q[48] ? t_neg : t_q;
  assign m_full = t_mag[48:11];
  assign q_prod = {14'd0, m_q} * RECIP_125_W;
  assign q_adj  = q_prod[25:20];

  assign prop_bias = $signed({24'd0, lfmc_pkg::PROP_BASE_SPEED, 8'd0});
  assign pe        = {prod_q[38], prod_q};
  assign pid_l     = $signed({2'b0, cfg_i.base_speed}) + {{3{adj_q[6]}}, adj_q};
  assign pid_r     = $signed({2'b0, cfg_i.base_speed}) - {{3{adj_q[6]}}, adj_q};

  assign spd_l_neg = -spd_l_q;
  assign spd_r_neg = -spd_r_q;
  assign mag_l     = spd_l_q[8] ? spd_l_neg[7:0] : spd_l_q[7:0];
  assign mag_r     = spd_r_q[8] ? spd_r_neg[7:0] : spd_r_q[7:0];
  assign span      = 8'd255 - cfg_i.dead_zone;

  assign band_lo = $signed({1'b0, cfg_i.gray_level}) - $signed({1'b0, cfg_i.band_threshold});
  assign band_hi = {1'b0, cfg_i.gray_level} + {1'b0, cfg_i.band_threshold};
  assign samp_s  = $signed({1'b0, sample_q});
  assign on_sum  = {1'b0, cfg_i.dead_zone} + {1'b0, lfmc_pkg::ON_BOOST};
  assign on_duty = on_sum[8] ? 8'hFF : on_sum[7:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      integ_q    <= 16'sd0;
      last_err_q <= 11'sd0;
      cnt_q      <= 5'd0;
    end else begin
      case (cmd_i.op)
        lfmc_pkg::OP_DIV_INIT:  cnt_q <= lfmc_pkg::DIV_STEPS;
        lfmc_pkg::OP_DIV_STEP:  cnt_q <= cnt_q - 5'd1;
        lfmc_pkg::OP_SPEED_PID: begin
          integ_q    <= acc_q;
          last_err_q <= err_q;
        end
        default: cnt_q <= cnt_q;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    case (cmd_i.op)
      lfmc_pkg::OP_LOAD: begin
        sample_q <= light_sample_i;
        ms_q     <= elapsed_ms_i;
        err_q    <= err_new;
      end
      lfmc_pkg::OP_ONOFF: begin
        if (samp_s < band_lo) begin
          left_duty_q  <= 8'd0;
          right_duty_q <= on_duty;
        end else if ({1'b0, sample_q} > band_hi) begin
          left_duty_q  <= on_duty;
          right_duty_q <= 8'd0;
        end else begin
          left_duty_q  <= on_duty;
          right_duty_q <= on_duty;
        end
        left_dir_q  <= lfmc_pkg::DIR_HOLD;
        right_dir_q <= lfmc_pkg::DIR_HOLD;
      end
      lfmc_pkg::OP_MUL_PROP, lfmc_pkg::OP_MUL_ACC, lfmc_pkg::OP_MUL_P: begin
        prod_q <= mul_full[38:0];
      end
      lfmc_pkg::OP_SPEED_PROP: begin
        spd_l_q <= clamp_speed(div256_trunc(prop_bias + pe));
        spd_r_q <= clamp_speed(div256_trunc(prop_bias - pe));
      end
      lfmc_pkg::OP_DIV_INIT: begin
        if (isum > lfmc_pkg::INTEG_MAX) begin
          acc_q <= lfmc_pkg::INTEG_HIGH;
        end else if (isum < lfmc_pkg::INTEG_MIN) begin
          acc_q <= lfmc_pkg::INTEG_LOW;
        end else begin
          acc_q <= isum[15:0];
        end
        neg_q <= num[21];
        dvd_q <= num[21] ? num_neg[20:0] : num[20:0];
        rem_q <= 16'd0;
      end
      lfmc_pkg::OP_DIV_STEP: begin
        if (!trial[17]) begin
          rem_q <= trial[15:0];
          dvd_q <= {dvd_q[19:0], 1'b1};
        end else begin
          rem_q <= shifted[15:0];
          dvd_q <= {dvd_q[19:0], 1'b0};
        end
      end
      lfmc_pkg::OP_MUL_D: begin
        t_q    <= {{10{prod_q[38]}}, prod_q};
        prod_q <= mul_full[38:0];
      end
      lfmc_pkg::OP_MUL_I: begin
        t_q    <= t_q + {{10{prod_q[38]}}, prod_q};
        prod_q <= mul_full[38:0];
      end
      lfmc_pkg::OP_SCALE: t_q <= (t_q <<< 10) - (t_q <<< 4) - (t_q <<< 3);
      lfmc_pkg::OP_SUM:   t_q <= t_q + {{10{prod_q[38]}}, prod_q};
      lfmc_pkg::OP_ADJ_SAT: begin
        adj_neg_q <= t_q[48];
        m_q       <= (m_full > {25'd0, lfmc_pkg::ADJ_M_MAX}) ? lfmc_pkg::ADJ_M_MAX
                                                              : m_full[12:0];
      end
      lfmc_pkg::OP_ADJ_MUL: begin
        adj_q <= adj_neg_q ? -$signed({1'b0, q_adj}) : $signed({1'b0, q_adj});
      end
      lfmc_pkg::OP_SPEED_PID: begin
        spd_l_q <= clamp_speed({{30{pid_l[9]}}, pid_l});
        spd_r_q <= clamp_speed({{30{pid_r[9]}}, pid_r});
      end
      lfmc_pkg::OP_WHEEL_MUL: begin
        wprod_l_q <= {8'd0, mag_l} * {8'd0, span};
        wprod_r_q <= {8'd0, mag_r} * {8'd0, span};
        wzero_l_q <= (spd_l_q == 9'sd0);
        wzero_r_q <= (spd_r_q == 9'sd0);
        wdir_l_q  <= (spd_l_q == 9'sd0) ? lfmc_pkg::DIR_HOLD :
                     (spd_l_q[8] ? lfmc_pkg::DIR_REV : lfmc_pkg::DIR_FWD);
        wdir_r_q  <= (spd_r_q == 9'sd0) ? lfmc_pkg::DIR_HOLD :
                     (spd_r_q[8] ? lfmc_pkg::DIR_REV : lfmc_pkg::DIR_FWD);
      end
      lfmc_pkg::OP_WHEEL_OUT: begin
        left_duty_q  <= duty_of(wprod_l_q, cfg_i.dead_zone, wzero_l_q);
        right_duty_q <= duty_of(wprod_r_q, cfg_i.dead_zone, wzero_r_q);
        left_dir_q   <= wdir_l_q;
        right_dir_q  <= wdir_r_q;
      end
      default: begin
        sample_q <= sample_q;
      end
    endcase
  end

  assign stat_o.ms_zero  = (ms_q == 16'd0);
  assign stat_o.div_done = (cnt_q == 5'd0);

  assign left_duty_o  = left_duty_q;
  assign right_duty_o = right_duty_q;
  assign left_dir_o   = left_dir_q;
  assign right_dir_o  = right_dir_q;

endmodule

// ===== src/lfmc_ctrl.sv =====
module lfmc_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  input  logic                 out_ready_i,
  input  logic [1:0]           mode_i,
  input  lfmc_pkg::stat_t      stat_i,
  output logic                 in_ready_o,
  output logic                 out_valid_o,
  output lfmc_pkg::cmd_t       cmd_o
);

  lfmc_pkg::ctrl_state_e state_q;
  lfmc_pkg::ctrl_state_e state_d;
  logic                  out_valid_q;
  logic                  out_valid_d;
  logic                  slot_free;
  logic                  out_load;

  // The result register may be refilled in the cycle its beat is taken.
  assign slot_free = !out_valid_q || out_ready_i;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      lfmc_pkg::ST_IDLE: begin
        if (in_valid_i) begin
          state_d = lfmc_pkg::ST_DISPATCH;
        end
      end
      lfmc_pkg::ST_DISPATCH: begin
        unique case (mode_i)
          lfmc_pkg::MODE_ONOFF: state_d = lfmc_pkg::ST_ONOFF;
          lfmc_pkg::MODE_PROP:  state_d = lfmc_pkg::ST_PMUL;
          lfmc_pkg::MODE_PID:   state_d = stat_i.ms_zero ? lfmc_pkg::ST_IDLE
                                                         : lfmc_pkg::ST_IMUL;
          default:              state_d = lfmc_pkg::ST_IDLE;
        endcase
      end
      lfmc_pkg::ST_ONOFF: begin
        if (slot_free) begin
          state_d = lfmc_pkg::ST_IDLE;
        end
      end
      lfmc_pkg::ST_PMUL:   state_d = lfmc_pkg::ST_PSPEED;
      lfmc_pkg::ST_PSPEED: state_d = lfmc_pkg::ST_WMUL;
      lfmc_pkg::ST_IMUL:   state_d = lfmc_pkg::ST_DINIT;
      lfmc_pkg::ST_DINIT:  state_d = lfmc_pkg::ST_DIV;
      lfmc_pkg::ST_DIV: begin
        if (stat_i.div_done) begin
          state_d = lfmc_pkg::ST_MULP;
        end
      end
      lfmc_pkg::ST_MULP:   state_d = lfmc_pkg::ST_MULD;
      lfmc_pkg::ST_MULD:   state_d = lfmc_pkg::ST_MULI;
      lfmc_pkg::ST_MULI:   state_d = lfmc_pkg::ST_SCALE;
      lfmc_pkg::ST_SCALE:  state_d = lfmc_pkg::ST_SUM;
      lfmc_pkg::ST_SUM:    state_d = lfmc_pkg::ST_ADJ1;
      lfmc_pkg::ST_ADJ1:   state_d = lfmc_pkg::ST_ADJ2;
      lfmc_pkg::ST_ADJ2:   state_d = lfmc_pkg::ST_SPEED;
      lfmc_pkg::ST_SPEED:  state_d = lfmc_pkg::ST_WMUL;
      lfmc_pkg::ST_WMUL:   state_d = lfmc_pkg::ST_WOUT;
      lfmc_pkg::ST_WOUT: begin
        if (slot_free) begin
          state_d = lfmc_pkg::ST_IDLE;
        end
      end
      default: state_d = lfmc_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_o.op   = lfmc_pkg::OP_NONE;
    in_ready_o = 1'b0;
    unique case (state_q)
      lfmc_pkg::ST_IDLE: begin
        in_ready_o = 1'b1;
        cmd_o.op   = in_valid_i ? lfmc_pkg::OP_LOAD : lfmc_pkg::OP_NONE;
      end
      lfmc_pkg::ST_DISPATCH: cmd_o.op = lfmc_pkg::OP_NONE;
      lfmc_pkg::ST_ONOFF:    cmd_o.op = slot_free ? lfmc_pkg::OP_ONOFF : lfmc_pkg::OP_NONE;
      lfmc_pkg::ST_PMUL:     cmd_o.op = lfmc_pkg::OP_MUL_PROP;
      lfmc_pkg::ST_PSPEED:   cmd_o.op = lfmc_pkg::OP_SPEED_PROP;
      lfmc_pkg::ST_IMUL:     cmd_o.op = lfmc_pkg::OP_MUL_ACC;
      lfmc_pkg::ST_DINIT:    cmd_o.op = lfmc_pkg::OP_DIV_INIT;
      lfmc_pkg::ST_DIV:      cmd_o.op = stat_i.div_done ? lfmc_pkg::OP_NONE
                                                        : lfmc_pkg::OP_DIV_STEP;
      lfmc_pkg::ST_MULP:     cmd_o.op = lfmc_pkg::OP_MUL_P;
      lfmc_pkg::ST_MULD:     cmd_o.op = lfmc_pkg::OP_MUL_D;
      lfmc_pkg::ST_MULI:     cmd_o.op = lfmc_pkg::OP_MUL_I;
      lfmc_pkg::ST_SCALE:    cmd_o.op = lfmc_pkg::OP_SCALE;
      lfmc_pkg::ST_SUM:      cmd_o.op = lfmc_pkg::OP_SUM;
      lfmc_pkg::ST_ADJ1:     cmd_o.op = lfmc_pkg::OP_ADJ_SAT;
      lfmc_pkg::ST_ADJ2:     cmd_o.op = lfmc_pkg::OP_ADJ_MUL;
      lfmc_pkg::ST_SPEED:    cmd_o.op = lfmc_pkg::OP_SPEED_PID;
      lfmc_pkg::ST_WMUL:     cmd_o.op = lfmc_pkg::OP_WHEEL_MUL;
      lfmc_pkg::ST_WOUT:     cmd_o.op = slot_free ? lfmc_pkg::OP_WHEEL_OUT
                                                  : lfmc_pkg::OP_NONE;
      default:               cmd_o.op = lfmc_pkg::OP_NONE;
    endcase
  end

  assign out_load = (cmd_o.op == lfmc_pkg::OP_ONOFF) || (cmd_o.op == lfmc_pkg::OP_WHEEL_OUT);

  always_comb begin
    out_valid_d = out_valid_q;
    if (out_load) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= lfmc_pkg::ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

// ===== src/line_follow_motor_controller.sv =====
// The result is loaded into the output register by the on/off step, or at the end of the
// proportional or PID arithmetic; in PID, a restoring divider forms the derivative, one
// quotient bit a cycle. The result waits until the output register is free; once it is
// loaded, the next beat can be taken while the result may still wait there. A PID beat
// with zero elapsed time, or an unused mode, gives no result and the next beat can follow.
// Asynchronous active-low reset restores the register defaults and clears integral and error.
module line_follow_motor_controller (
  input  logic        clk_i,
  input  logic        rst_ni,
  lfmc_in_if.sink     in_i,
  lfmc_out_if.source  out_o,
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_idx_i,
  input  logic [15:0] cfg_wdata_i
);

  lfmc_pkg::cfg_t  cfg;
  lfmc_pkg::cmd_t  cmd;
  lfmc_pkg::stat_t stat;
  logic            in_ready;
  logic            out_valid;

  lfmc_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .we_i    (cfg_we_i),
    .idx_i   (cfg_idx_i),
    .wdata_i (cfg_wdata_i),
    .cfg_o   (cfg)
  );

  lfmc_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_i.valid),
    .out_ready_i (out_o.ready),
    .mode_i      (cfg.mode),
    .stat_i      (stat),
    .in_ready_o  (in_ready),
    .out_valid_o (out_valid),
    .cmd_o       (cmd)
  );

  lfmc_dp u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_i          (cfg),
    .cmd_i          (cmd),
    .light_sample_i (in_i.light_sample),
    .elapsed_ms_i   (in_i.elapsed_ms),
    .stat_o         (stat),
    .left_duty_o    (out_o.left_duty),
    .right_duty_o   (out_o.right_duty),
    .left_dir_o     (out_o.left_dir),
    .right_dir_o    (out_o.right_dir)
  );

  assign in_i.ready  = in_ready;
  assign out_o.valid = out_valid;

  a_one_beat_at_a_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_i.valid && in_i.ready) |=> !in_i.ready)
    else $error("input taken while a beat is still being processed");

  a_result_slot_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((cmd.op == lfmc_pkg::OP_ONOFF) || (cmd.op == lfmc_pkg::OP_WHEEL_OUT))
    |-> (!out_o.valid || out_o.ready))
    else $error("result register overwritten before its beat was taken");

  a_valid_from_load: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_o.valid)
    |-> $past((cmd.op == lfmc_pkg::OP_ONOFF) || (cmd.op == lfmc_pkg::OP_WHEEL_OUT)))
    else $error("result valid raised without a result load");

  a_div_bounded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd.op == lfmc_pkg::OP_DIV_STEP) |-> !stat.div_done)
    else $error("divider stepped past its last quotient bit");

endmodule

// ===== sim/tb_line_follow_motor_controller.sv =====
module tb_line_follow_motor_controller;
  import lfmc_pkg::*;

  localparam int TAIL_CYCLES = 60;
  localparam int CYCLE_LIMIT = 600000;

  typedef struct packed {
    logic [7:0] left_duty;
    logic [7:0] right_duty;
    logic [1:0] left_dir;
    logic [1:0] right_dir;
  } drive_t;

  typedef enum {READY_ALWAYS, READY_COIN, READY_SPARSE, READY_PATTERN} ready_style_e;

  class drive_scoreboard;
    cfg_t                cfg;
    logic signed [15:0]  integral;
    logic signed [10:0]  prev_err;
    drive_t              expected_drives[$];
    int                  fail_count;

    function new();
      cfg        = CFG_RESET;
      integral   = '0;
      prev_err   = '0;
      fail_count = 0;
    endfunction

    function void write_reg(reg_idx_e idx, logic [15:0] v);
      case (idx)
        REG_MODE:           cfg.mode = v[1:0];
        REG_GRAY_LEVEL:     cfg.gray_level = v[9:0];
        REG_BAND_THRESHOLD: cfg.band_threshold = v[9:0];
        REG_DEAD_ZONE:      cfg.dead_zone = v[7:0];
        REG_BASE_SPEED:     cfg.base_speed = v[7:0];
        REG_GAIN_P:         cfg.gain_p = v;
        REG_GAIN_I:         cfg.gain_i = v;
        REG_GAIN_D:         cfg.gain_d = v;
        default: ;
      endcase
    endfunction

    function void wheel_drive(longint speed, output logic [7:0] duty, output logic [1:0] dir);
      longint mag;
      longint dz;
      dz = longint'(cfg.dead_zone);
      if (speed > SPEED_MAX) speed = SPEED_MAX;
      if (speed < SPEED_MIN) speed = SPEED_MIN;
      if (speed == 0) begin
        duty = '0;
        dir  = DIR_HOLD;
      end else begin
        dir  = (speed > 0) ? DIR_FWD : DIR_REV;
        mag  = (speed > 0) ? speed : -speed;
        duty = 8'((mag * (255 - dz)) / 255 + dz);
      end
    endfunction

    function void note_input(logic [9:0] sample, logic [15:0] ms);
      longint s, t, err, lo, hi, acc, der, sum, adj, pe;
      int     on_duty;
      drive_t d;
      s   = longint'(sample);
      t   = longint'(ms);
      err = s - longint'(cfg.gray_level);
      d   = '0;
      case (cfg.mode)
        MODE_ONOFF: begin
          lo = longint'(cfg.gray_level) - longint'(cfg.band_threshold);
          hi = longint'(cfg.gray_level) + longint'(cfg.band_threshold);
          on_duty = int'(cfg.dead_zone) + int'(ON_BOOST);
          if (on_duty > 255) on_duty = 255;
          if (s < lo) begin
            d.right_duty = 8'(on_duty);
          end else if (s > hi) begin
            d.left_duty = 8'(on_duty);
          end else begin
            d.left_duty  = 8'(on_duty);
            d.right_duty = 8'(on_duty);
          end
          d.left_dir  = DIR_HOLD;
          d.right_dir = DIR_HOLD;
          expected_drives.push_back(d);
        end
        MODE_PROP: begin
          pe = longint'(PROP_GAIN_Q8) * err;
          wheel_drive((longint'(PROP_BASE_SPEED) * 256 + pe) / 256, d.left_duty, d.left_dir);
          wheel_drive((longint'(PROP_BASE_SPEED) * 256 - pe) / 256, d.right_duty, d.right_dir);
          expected_drives.push_back(d);
        end
        MODE_PID: begin
          if (t != 0) begin
            acc = longint'(integral) + err * t;
            if (acc > longint'(INTEG_MAX)) acc = INTEG_MAX;
            if (acc < longint'(INTEG_MIN)) acc = INTEG_MIN;
            der = ((err - longint'(prev_err)) * 1000) / t;
            sum = longint'(cfg.gain_p) * err * 1000 + longint'(cfg.gain_i) * acc
                + longint'(cfg.gain_d) * der * 1000;
            adj = sum / 256000;
            if (adj > 50) adj = 50;
            if (adj < -50) adj = -50;
            integral = 16'(acc);
            prev_err = 11'(err);
            wheel_drive(longint'(cfg.base_speed) + adj, d.left_duty, d.left_dir);
            wheel_drive(longint'(cfg.base_speed) - adj, d.right_duty, d.right_dir);
            expected_drives.push_back(d);
          end
        end
        default: ;
      endcase
    endfunction

    function void check_result(drive_t got);
      drive_t want;
      if (expected_drives.size() == 0) begin
        $error("unexpected beat: left_duty %0d right_duty %0d left_dir %0d right_dir %0d",
               got.left_duty, got.right_duty, got.left_dir, got.right_dir);
        fail_count++;
        return;
      end
      want = expected_drives.pop_front();
      if (got.left_duty !== want.left_duty) begin
        $error("left_duty expected %0d actual %0d", want.left_duty, got.left_duty);
        fail_count++;
      end
      if (got.right_duty !== want.right_duty) begin
        $error("right_duty expected %0d actual %0d", want.right_duty, got.right_duty);
        fail_count++;
      end
      if (got.left_dir !== want.left_dir) begin
        $error("left_dir expected %0d actual %0d", want.left_dir, got.left_dir);
        fail_count++;
      end
      if (got.right_dir !== want.right_dir) begin
        $error("right_dir expected %0d actual %0d", want.right_dir, got.right_dir);
        fail_count++;
      end
    endfunction

    function int pending();
      return expected_drives.size();
    endfunction
  endclass

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_we_i;
  logic [2:0]  cfg_idx_i;
  logic [15:0] cfg_wdata_i;

  lfmc_in_if  in_if ();
  lfmc_out_if out_if ();

  line_follow_motor_controller dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_i        (in_if),
    .out_o       (out_if),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i)
  );

  drive_scoreboard sb = new();
  int              cycle_count = 0;
  int              burst_left = 0;
  ready_style_e    ready_style = READY_ALWAYS;

  always #5 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count % 128 == 0) ready_style <= ready_style_e'($urandom_range(0, 3));
    case (ready_style)
      READY_ALWAYS:  out_if.ready <= 1'b1;
      READY_COIN:    out_if.ready <= 1'($urandom_range(0, 1));
      READY_SPARSE:  out_if.ready <= ($urandom_range(0, 3) == 0);
      default:       out_if.ready <= cycle_count[3];
    endcase
    if (cycle_count > CYCLE_LIMIT) begin
      $display("line_follow_motor_controller verification failed");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_if.valid && out_if.ready) begin
      sb.check_result(drive_t'{left_duty:  out_if.left_duty,
                               right_duty: out_if.right_duty,
                               left_dir:   out_if.left_dir,
                               right_dir:  out_if.right_dir});
    end
  end

  task automatic send_item(logic [9:0] sample, logic [15:0] ms);
    int gap;
    if (burst_left == 0) begin
      gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      burst_left = $urandom_range(1, 24);
      if (gap > 0) begin
        in_if.valid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
    in_if.valid        <= 1'b1;
    in_if.light_sample <= sample;
    in_if.elapsed_ms   <= ms;
    @(posedge clk_i);
    while (!in_if.ready) @(posedge clk_i);
    sb.note_input(sample, ms);
    burst_left--;
  endtask

  task automatic drain();
    in_if.valid <= 1'b0;
    burst_left = 0;
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (TAIL_CYCLES) @(posedge clk_i);
  endtask

  task automatic apply_config(cfg_t c);
    reg_idx_e    idx;
    logic [15:0] val;
    for (int k = 0; k < 8; k++) begin
      idx = reg_idx_e'(k);
      case (idx)
        REG_MODE:           val = 16'(c.mode);
        REG_GRAY_LEVEL:     val = 16'(c.gray_level);
        REG_BAND_THRESHOLD: val = 16'(c.band_threshold);
        REG_DEAD_ZONE:      val = 16'(c.dead_zone);
        REG_BASE_SPEED:     val = 16'(c.base_speed);
        REG_GAIN_P:         val = c.gain_p;
        REG_GAIN_I:         val = c.gain_i;
        default:            val = c.gain_d;
      endcase
      @(posedge clk_i);
      cfg_we_i    <= 1'b1;
      cfg_idx_i   <= idx;
      cfg_wdata_i <= val;
      sb.write_reg(idx, val);
    end
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  function automatic int unsigned pick_value(int unsigned top);
    case ($urandom_range(0, 5))
      0:       return 0;
      1:       return top;
      default: return $urandom_range(0, top);
    endcase
  endfunction

  function automatic logic [15:0] pick_gain();
    case ($urandom_range(0, 5))
      0:       return 16'd0;
      1:       return 16'hFFFF;
      2, 3:    return 16'($urandom_range(0, 1023));
      default: return 16'($urandom_range(0, 65535));
    endcase
  endfunction

  function automatic cfg_t random_cfg(logic [1:0] m);
    cfg_t c;
    c.mode           = m;
    c.gray_level     = 10'(pick_value(1023));
    c.band_threshold = ($urandom_range(0, 2) == 0) ? 10'(pick_value(1023))
                                                   : 10'($urandom_range(0, 150));
    c.dead_zone      = 8'(pick_value(255));
    c.base_speed     = 8'(pick_value(255));
    c.gain_p         = pick_gain();
    c.gain_i         = pick_gain();
    c.gain_d         = pick_gain();
    return c;
  endfunction

  function automatic logic [9:0] rand_sample(logic [9:0] gray);
    int v;
    case ($urandom_range(0, 9))
      0, 1, 2, 3: v = int'(gray) + int'($urandom_range(0, 128)) - 64;
      4:          v = 0;
      5:          v = 1023;
      default:    v = int'($urandom_range(0, 1023));
    endcase
    if (v < 0) v = 0;
    if (v > 1023) v = 1023;
    return 10'(v);
  endfunction

  function automatic logic [15:0] rand_ms();
    case ($urandom_range(0, 19))
      0, 1:               return 16'd0;
      2, 3:               return 16'hFFFF;
      4, 5, 6:            return 16'($urandom_range(51, 1000));
      7, 8, 9:            return 16'($urandom_range(0, 65535));
      default:            return 16'($urandom_range(1, 50));
    endcase
  endfunction

  initial begin
    int phase_modes[13] = '{2, 0, 1, 2, 2, 0, 2, 1, 3, 2, 0, 1, 2};
    int n_items;
    in_if.valid        <= 1'b0;
    in_if.light_sample <= '0;
    in_if.elapsed_ms   <= '0;
    cfg_we_i           <= 1'b0;
    cfg_idx_i          <= REG_MODE;
    cfg_wdata_i        <= '0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Settings left by reset: PID with unity proportional gain.
    send_item(10'd512, 16'd1);
    send_item(10'd1023, 16'hFFFF);
    send_item(10'd0, 16'd1);
    send_item(10'd300, 16'd0);
    drain();

    // On/off with the boosted duty saturating, samples on each side of the band edges.
    apply_config('{MODE_ONOFF, 10'd512, 10'd100, 8'd230, 8'd0, 16'd0, 16'd0, 16'd0});
    send_item(10'd0, 16'd0);
    send_item(10'd411, 16'hFFFF);
    send_item(10'd412, 16'd0);
    send_item(10'd612, 16'hFFFF);
    send_item(10'd613, 16'd0);
    send_item(10'd1023, 16'd7);
    drain();

    // Proportional: both clamps and each wheel reaching zero speed.
    apply_config('{MODE_PROP, 10'd512, 10'd1023, 8'd40, 8'd255, 16'hFFFF, 16'hFFFF,
                   16'hFFFF});
    send_item(10'd0, 16'd0);
    send_item(10'd1023, 16'hFFFF);
    send_item(10'd662, 16'd3);
    send_item(10'd362, 16'd0);
    drain();

    apply_config('{MODE_PID, 10'd1023, 10'd1023, 8'd255, 8'd255, 16'hFFFF, 16'hFFFF,
                   16'hFFFF});
    send_item(10'd0, 16'hFFFF);
    send_item(10'd0, 16'd1);
    send_item(10'd1023, 16'd1);
    send_item(10'd1023, 16'd0);
    drain();

    apply_config('{MODE_PID, 10'd0, 10'd0, 8'd0, 8'd0, 16'd0, 16'd0, 16'd0});
    send_item(10'd100, 16'd5);
    drain();

    // The unused mode takes beats and answers none of them.
    apply_config('{2'd3, 10'd512, 10'd100, 8'd10, 8'd100, 16'd256, 16'd0, 16'd0});
    send_item(10'd700, 16'd9);
    send_item(10'd5, 16'd0);
    drain();

    foreach (phase_modes[p]) begin
      apply_config(random_cfg(2'(phase_modes[p])));
      n_items = (phase_modes[p] == 3) ? 8 : 65;
      repeat (n_items) send_item(rand_sample(sb.cfg.gray_level), rand_ms());
      drain();
    end

    if (sb.fail_count == 0 && sb.pending() == 0) begin
      $display("line_follow_motor_controller verification clean");
    end else begin
      $display("line_follow_motor_controller verification failed");
    end
    $finish;
  end

endmodule
